/* rtl/scds_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse coordinate descent step package
// Transaction types and codes shared by the coordinate descent step unit.
// ----------------------------------------------------------------------------
package scds_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE_ENTRY  = 2'd0,
    ACT_WRITE_TARGET = 2'd1,
    ACT_STEP         = 2'd2,
    ACT_READ_COORD   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_NORM = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_e;

  typedef struct packed {
    action_e            action;
    logic [9:0]         column;
    logic [1:0]         slot;
    logic [11:0]        row;
    logic signed [15:0] entry_value;
    logic signed [31:0] target_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] coord_value;
    logic signed [31:0] step_delta;
    status_e            status;
  } out_t;

endpackage

/* rtl/scds_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sparse_coordinate_descent_step_unit.sv */
// ----------------------------------------------------------------------------
// Sparse coordinate descent step unit
// Stores a sparse matrix with SLOTS nonzeros per column and a residual
// vector, and performs least-squares coordinate descent steps on them.
// ----------------------------------------------------------------------------
//  Channel   Ports                 Direction  Transfer
//  command   start_i, item_i       in         start_i high while busy_o is low
//  result    done_o, result_o      out        done_o high for one cycle
//
// A step makes a pass over the slots with the shared multiplier, divides
// with the radix-2 divider and makes a second multiplier pass over the
// slots; a step whose quotient overflows skips the divider. After reset
// the block clears its memories with busy_o high. The receiver cannot
// stall results.
// ----------------------------------------------------------------------------
module sparse_coordinate_descent_step_unit #(
  parameter int COLUMNS = 1024,
  parameter int SLOTS   = 4,
  parameter int ROWS    = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  scds_pkg::in_t  item_i,
  output logic           busy_o,
  output logic           done_o,
  output scds_pkg::out_t result_o
);

  localparam int EDEPTH = COLUMNS * SLOTS;
  localparam int EAW    = EDEPTH > 1 ? $clog2(EDEPTH) : 1;
  localparam int CAW    = COLUMNS > 1 ? $clog2(COLUMNS) : 1;
  localparam int RAW    = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int SIW    = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CLR0   = EDEPTH > ROWS ? EDEPTH : ROWS;
  localparam int CLR    = CLR0 > COLUMNS ? CLR0 : COLUMNS;
  localparam int CLW    = CLR > 1 ? $clog2(CLR) : 1;
  localparam int DW     = 48 + $clog2(SLOTS);
  localparam int NW     = 31 + $clog2(SLOTS);
  localparam int CW     = NW + 18;

  typedef enum logic [16:0] {
    ST_CLEAR  = 17'h00001,
    ST_IDLE   = 17'h00002,
    ST_CRD    = 17'h00004,
    ST_P1_ENT = 17'h00008,
    ST_P1_RES = 17'h00010,
    ST_P1_M1  = 17'h00020,
    ST_P1_M2  = 17'h00040,
    ST_P1_ACC = 17'h00080,
    ST_DCHK   = 17'h00100,
    ST_DOVF   = 17'h00200,
    ST_DIV    = 17'h00400,
    ST_DELTA  = 17'h00800,
    ST_CUPD   = 17'h01000,
    ST_P2_ENT = 17'h02000,
    ST_P2_RES = 17'h04000,
    ST_P2_MUL = 17'h08000,
    ST_P2_WR  = 17'h10000
  } state_e;

  function automatic logic [31:0] sat35(input logic [34:0] v);
    if (v[34:31] == 4'h0 || v[34:31] == 4'hF) begin
      return v[31:0];
    end
    return v[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic ovf35(input logic [34:0] v);
    return !(v[34:31] == 4'h0 || v[34:31] == 4'hF);
  endfunction

  state_e                state_q, state_d;
  logic [CLW-1:0]        clr_q, clr_d;
  logic [SIW-1:0]        s_q, s_d;
  logic [4:0]            cnt_q, cnt_d;
  scds_pkg::action_e     act_q, act_d;
  logic [9:0]            col_q, col_d;
  logic                  colok_q, colok_d;
  logic                  tsat_q, tsat_d;
  logic                  sat_q, sat_d;
  logic                  neg_q, neg_d;
  logic signed [31:0]    coord_q, coord_d;
  logic signed [31:0]    delta_q, delta_d;
  logic signed [31:0]    res_q, res_d;
  logic signed [DW-1:0]  dot_q, dot_d;
  logic [NW-1:0]         norm_q, norm_d;
  logic [DW-1:0]         mag_q, mag_d;
  logic [NW-1:0]         rem_q, rem_d;
  logic [31:0]           num_q, num_d;
  logic signed [47:0]    prod_q, prod_d;
  logic signed [33:0]    inc_q, inc_d;
  logic                  done_q, done_d;
  scds_pkg::out_t        out_q, out_d;

  logic signed [31:0]    mul_a;
  logic signed [15:0]    mul_b;

  logic                  ent_we, crd_we, res_we;
  logic [EAW-1:0]        ent_waddr, ent_raddr;
  logic [27:0]           ent_wdata, ent_rdata;
  logic [CAW-1:0]        crd_waddr, crd_raddr;
  logic [31:0]           crd_wdata, crd_rdata;
  logic [RAW-1:0]        res_waddr, res_raddr;
  logic [31:0]           res_wdata, res_rdata;

  logic                  accept;
  logic                  last_slot;
  logic signed [15:0]    ent_val;
  logic [11:0]           ent_row;
  logic [32:0]           neg_tv;
  logic [NW:0]           trial;
  logic [34:0]           csum, rsum;
  logic signed [47:0]    rnd;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign busy_o    = (state_q != ST_IDLE);
  assign last_slot = (s_q == SIW'(SLOTS - 1));
  assign ent_val   = ent_rdata[15:0];
  assign ent_row   = ent_rdata[27:16];
  assign ent_raddr = EAW'(col_q) * EAW'(SLOTS) + EAW'(s_q);
  assign res_raddr = RAW'(ent_row);
  assign crd_raddr = CAW'(item_i.column);
  assign neg_tv    = 33'd0 - {item_i.target_value[31], item_i.target_value};
  assign trial     = {rem_q, num_q[31]};
  assign csum      = {{3{coord_q[31]}}, coord_q} + {{3{delta_q[31]}}, delta_q};
  assign rsum      = {{3{res_q[31]}}, res_q} + {inc_q[33], inc_q};
  assign rnd       = prod_q + 48'sd8192;
  assign prod_d    = 48'(mul_a) * 48'(mul_b);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    s_d     = s_q;
    cnt_d   = cnt_q;
    act_d   = act_q;
    col_d   = col_q;
    colok_d = colok_q;
    tsat_d  = tsat_q;
    sat_d   = sat_q;
    neg_d   = neg_q;
    coord_d = coord_q;
    delta_d = delta_q;
    res_d   = res_q;
    dot_d   = dot_q;
    norm_d  = norm_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    num_d   = num_q;
    inc_d   = inc_q;
    done_d  = 1'b0;
    out_d   = out_q;
    mul_a   = '0;
    mul_b   = '0;
    ent_we    = 1'b0;
    ent_waddr = EAW'(item_i.column) * EAW'(SLOTS) + EAW'(item_i.slot);
    ent_wdata = {item_i.row, item_i.entry_value};
    crd_we    = 1'b0;
    crd_waddr = CAW'(col_q);
    crd_wdata = sat35(csum);
    res_we    = 1'b0;
    res_waddr = RAW'(item_i.row);
    res_wdata = (neg_tv[32] != neg_tv[31]) ? 32'h7FFF_FFFF : neg_tv[31:0];

    unique case (state_q)
      ST_CLEAR: begin
        ent_we    = (32'(clr_q) < 32'(EDEPTH));
        ent_waddr = clr_q[EAW-1:0];
        ent_wdata = '0;
        crd_we    = (32'(clr_q) < 32'(COLUMNS));
        crd_waddr = clr_q[CAW-1:0];
        crd_wdata = '0;
        res_we    = (32'(clr_q) < 32'(ROWS));
        res_waddr = clr_q[RAW-1:0];
        res_wdata = '0;
        clr_d     = clr_q + CLW'(1);
        if (clr_q == CLW'(CLR - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          act_d   = item_i.action;
          col_d   = item_i.column;
          colok_d = (32'(item_i.column) < 32'(COLUMNS));
          tsat_d  = (item_i.action == scds_pkg::ACT_WRITE_TARGET) &&
                    (32'(item_i.row) < 32'(ROWS)) && (neg_tv[32] != neg_tv[31]);
          ent_we  = (item_i.action == scds_pkg::ACT_WRITE_ENTRY) &&
                    (32'(item_i.column) < 32'(COLUMNS)) &&
                    (32'(item_i.slot) < 32'(SLOTS)) &&
                    (32'(item_i.row) < 32'(ROWS));
          res_we  = (item_i.action == scds_pkg::ACT_WRITE_TARGET) &&
                    (32'(item_i.row) < 32'(ROWS));
          state_d = ST_CRD;
        end
      end
      ST_CRD: begin
        coord_d = crd_rdata;
        dot_d   = '0;
        norm_d  = '0;
        s_d     = '0;
        sat_d   = 1'b0;
        if (act_q == scds_pkg::ACT_STEP && colok_q) begin
          state_d = ST_P1_ENT;
        end else begin
          done_d            = 1'b1;
          out_d.coord_value = colok_q ? crd_rdata : 32'sd0;
          out_d.step_delta  = 32'sd0;
          out_d.status      = tsat_q ? scds_pkg::STATUS_SATURATED : scds_pkg::STATUS_OK;
          state_d           = ST_IDLE;
        end
      end
      ST_P1_ENT: state_d = ST_P1_RES;
      ST_P1_RES: state_d = ST_P1_M1;
      ST_P1_M1: begin
        mul_a   = res_rdata;
        mul_b   = ent_val;
        state_d = ST_P1_M2;
      end
      ST_P1_M2: begin
        dot_d   = dot_q + DW'(prod_q);
        mul_a   = 32'(ent_val);
        mul_b   = ent_val;
        state_d = ST_P1_ACC;
      end
      ST_P1_ACC: begin
        norm_d = norm_q + NW'(prod_q);
        s_d    = s_q + SIW'(1);
        if (last_slot) begin
          state_d = ST_DCHK;
        end else begin
          state_d = ST_P1_ENT;
        end
      end
      ST_DCHK: begin
        if (norm_q == '0) begin
          done_d            = 1'b1;
          out_d.coord_value = coord_q;
          out_d.step_delta  = 32'sd0;
          out_d.status      = scds_pkg::STATUS_ZERO_NORM;
          state_d           = ST_IDLE;
        end else begin
          neg_d   = dot_q[DW-1];
          mag_d   = dot_q[DW-1] ? DW'(-dot_q) : DW'(dot_q);
          state_d = ST_DOVF;
        end
      end
      ST_DOVF: begin
        if (CW'(mag_q) >= {norm_q, 18'd0}) begin
          num_d   = '1;
          state_d = ST_DELTA;
        end else begin
          rem_d   = NW'(mag_q >> 18);
          num_d   = {mag_q[17:0], 14'd0};
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, norm_q}) begin
          rem_d = NW'(trial - {1'b0, norm_q});
          num_d = {num_q[30:0], 1'b1};
        end else begin
          rem_d = NW'(trial);
          num_d = {num_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = ST_DELTA;
        end
      end
      ST_DELTA: begin
        if (neg_q) begin
          if (num_q[31]) begin
            delta_d = 32'sh7FFF_FFFF;
            sat_d   = 1'b1;
          end else begin
            delta_d = num_q;
          end
        end else begin
          if (num_q > 32'h8000_0000) begin
            delta_d = 32'sh8000_0000;
            sat_d   = 1'b1;
          end else begin
            delta_d = 32'd0 - num_q;
          end
        end
        state_d = ST_CUPD;
      end
      ST_CUPD: begin
        crd_we  = 1'b1;
        coord_d = sat35(csum);
        sat_d   = sat_q | ovf35(csum);
        s_d     = '0;
        state_d = ST_P2_ENT;
      end
      ST_P2_ENT: state_d = ST_P2_RES;
      ST_P2_RES: state_d = ST_P2_MUL;
      ST_P2_MUL: begin
        res_d   = res_rdata;
        mul_a   = delta_q;
        mul_b   = ent_val;
        state_d = ST_P2_WR;
        cnt_d   = '0;
      end
      ST_P2_WR: begin
        if (cnt_q == 5'd0) begin
          inc_d = rnd[47:14];
          cnt_d = 5'd1;
        end else begin
          res_we    = 1'b1;
          res_waddr = RAW'(ent_row);
          res_wdata = sat35(rsum);
          sat_d     = sat_q | ovf35(rsum);
          s_d       = s_q + SIW'(1);
          if (last_slot) begin
            done_d            = 1'b1;
            out_d.coord_value = coord_q;
            out_d.step_delta  = delta_q;
            out_d.status      = (sat_q | ovf35(rsum)) ? scds_pkg::STATUS_SATURATED
                                                      : scds_pkg::STATUS_OK;
            state_d           = ST_IDLE;
          end else begin
            state_d = ST_P2_ENT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      s_q     <= '0;
      cnt_q   <= '0;
      act_q   <= scds_pkg::ACT_WRITE_ENTRY;
      colok_q <= 1'b0;
      tsat_q  <= 1'b0;
      sat_q   <= 1'b0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      s_q     <= s_d;
      cnt_q   <= cnt_d;
      act_q   <= act_d;
      colok_q <= colok_d;
      tsat_q  <= tsat_d;
      sat_q   <= sat_d;
      neg_q   <= neg_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    coord_q <= coord_d;
    delta_q <= delta_d;
    res_q   <= res_d;
    dot_q   <= dot_d;
    norm_q  <= norm_d;
    mag_q   <= mag_d;
    rem_q   <= rem_d;
    num_q   <= num_d;
    prod_q  <= prod_d;
    inc_q   <= inc_d;
    out_q   <= out_d;
  end

  scds_ram #(.WIDTH(28), .DEPTH(EDEPTH)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  scds_ram #(.WIDTH(32), .DEPTH(COLUMNS)) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (crd_we),
    .waddr_i (crd_waddr),
    .wdata_i (crd_wdata),
    .raddr_i (crd_raddr),
    .rdata_o (crd_rdata)
  );

  scds_ram #(.WIDTH(32), .DEPTH(ROWS)) u_resid_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .raddr_i (res_raddr),
    .rdata_o (res_rdata)
  );

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Coordinate descent step unit testbench
// Drives entry loads, target loads, coordinate steps and coordinate reads
// through the command handshake with random gaps. Every result is checked
// against an in-bench model of the matrix, residual and coordinate stores.
// ----------------------------------------------------------------------------
module tb;

  localparam int COLUMNS = 1024;
  localparam int SLOTS   = 4;
  localparam int ROWS    = 4096;

  typedef struct {
    scds_pkg::out_t predicted;
    bit             pinned;
    scds_pkg::out_t pinned_val;
  } pending_t;

  typedef struct {
    scds_pkg::in_t  item;
    bit             pinned;
    scds_pkg::out_t pinned_val;
  } vector_t;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  scds_pkg::in_t  item_i;
  logic           busy_o;
  logic           done_o;
  scds_pkg::out_t result_o;

  logic signed [15:0] mat_val [COLUMNS*SLOTS];
  logic [11:0]        mat_row [COLUMNS*SLOTS];
  logic signed [31:0] coord   [COLUMNS];
  logic signed [31:0] resid   [ROWS];

  pending_t pending_q [$];
  vector_t  vectors [$];
  bit       failed;

  sparse_coordinate_descent_step_unit dut (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .done_o, .result_o
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic logic signed [31:0] clip32(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic scds_pkg::out_t descend(input scds_pkg::in_t it);
    scds_pkg::out_t o;
    bit sat;
    longint dot, dfull, inc, v;
    longint unsigned norm, mag, q, rem, m;
    int base;
    logic signed [31:0] delta;
    sat = 1'b0;
    o = '{coord_value: 0, step_delta: 0, status: scds_pkg::STATUS_OK};
    case (it.action)
      scds_pkg::ACT_WRITE_ENTRY: begin
        base = int'(it.column) * SLOTS + int'(it.slot);
        mat_val[base] = it.entry_value;
        mat_row[base] = it.row;
        o.coord_value = coord[it.column];
      end
      scds_pkg::ACT_WRITE_TARGET: begin
        resid[it.row] = clip32(-longint'(it.target_value), sat);
        o.coord_value = coord[it.column];
        if (sat) o.status = scds_pkg::STATUS_SATURATED;
      end
      scds_pkg::ACT_READ_COORD: o.coord_value = coord[it.column];
      default: begin
        base = int'(it.column) * SLOTS;
        dot = 0;
        norm = 0;
        for (int s = 0; s < SLOTS; s++) begin
          v = mat_val[base+s];
          dot += v * longint'(resid[mat_row[base+s]]);
          norm += longint'(v * v);
        end
        o.coord_value = coord[it.column];
        if (norm == 0) begin
          o.status = scds_pkg::STATUS_ZERO_NORM;
        end else begin
          mag = (dot < 0) ? -dot : dot;
          q = mag / norm;
          rem = mag % norm;
          if (q >= 64'h1_0000_0000) begin
            dfull = (dot < 0) ? 64'sd2147483648 : -64'sd2147483649;
          end else begin
            m = (q << 14) + ((rem << 14) / norm);
            dfull = (dot < 0) ? longint'(m) : -longint'(m);
          end
          delta = clip32(dfull, sat);
          coord[it.column] = clip32(longint'(coord[it.column]) + delta, sat);
          for (int s = 0; s < SLOTS; s++) begin
            v = mat_val[base+s];
            inc = (longint'(delta) * v + 8192) >>> 14;
            resid[mat_row[base+s]] =
              clip32(longint'(resid[mat_row[base+s]]) + inc, sat);
          end
          o.coord_value = coord[it.column];
          o.step_delta = delta;
          if (sat) o.status = scds_pkg::STATUS_SATURATED;
        end
      end
    endcase
    return o;
  endfunction

  function automatic scds_pkg::in_t make_item(scds_pkg::action_e a, int col, int sl, int rw,
                                              int ev, int tv);
    scds_pkg::in_t it;
    it.action = a;
    it.column = 10'(col);
    it.slot = 2'(sl);
    it.row = 12'(rw);
    it.entry_value = 16'(ev);
    it.target_value = 32'(tv);
    return it;
  endfunction

  function automatic scds_pkg::in_t random_item();
    scds_pkg::in_t it;
    int pick;
    it = '0;
    pick = $urandom_range(0, 99);
    it.action = pick < 35 ? scds_pkg::ACT_WRITE_ENTRY :
                pick < 50 ? scds_pkg::ACT_WRITE_TARGET :
                pick < 85 ? scds_pkg::ACT_STEP : scds_pkg::ACT_READ_COORD;
    it.column = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
    it.slot = 2'($urandom);
    it.row = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 31));
    case ($urandom_range(0, 9))
      0: it.entry_value = 16'sd16384;
      1: it.entry_value = -16'sd16384;
      2: it.entry_value = 16'($urandom);
      3: it.entry_value = 16'sd0;
      default: it.entry_value = 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
    case ($urandom_range(0, 9))
      0: it.target_value = 32'($urandom);
      1: it.target_value = 32'sh80000000;
      default: it.target_value = int'($urandom_range(0, 2097152)) - 1048576;
    endcase
    return it;
  endfunction

  task automatic issue(input scds_pkg::in_t it, input bit pinned, input scds_pkg::out_t pv);
    pending_t p;
    item_i = it;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    p.predicted = descend(it);
    p.pinned = pinned;
    p.pinned_val = pv;
    pending_q.push_back(p);
    @(negedge clk_i);
    if ($urandom_range(0, 2) != 0) begin
      start_i = 1'b0;
      item_i = random_item();
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                         : $urandom_range(0, 3))
        @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    pending_t p;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, result_o);
        failed = 1'b1;
      end else begin
        p = pending_q.pop_front();
        if (result_o !== p.predicted) begin
          $display("%0t mismatch expected %p actual %p", $time, p.predicted, result_o);
          failed = 1'b1;
        end
        if (p.pinned && result_o !== p.pinned_val) begin
          $display("%0t mismatch expected %p actual %p", $time, p.pinned_val, result_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    scds_pkg::out_t none;
    failed = 1'b0;
    none = '0;
    foreach (mat_val[i]) mat_val[i] = 0;
    foreach (mat_row[i]) mat_row[i] = 0;
    foreach (coord[i]) coord[i] = 0;
    foreach (resid[i]) resid[i] = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    vectors.push_back('{make_item(scds_pkg::ACT_READ_COORD, 1023, 0, 0, 0, 0), 1,
                        '{0, 0, scds_pkg::STATUS_OK}});
    vectors.push_back('{make_item(scds_pkg::ACT_STEP, 5, 0, 0, 0, 0), 1,
                        '{0, 0, scds_pkg::STATUS_ZERO_NORM}});
    vectors.push_back('{make_item(scds_pkg::ACT_WRITE_ENTRY, 0, 0, 0, 16384, 0), 1,
                        '{0, 0, scds_pkg::STATUS_OK}});
    vectors.push_back('{make_item(scds_pkg::ACT_WRITE_ENTRY, 0, 3, 4095, -16384, 0), 1,
                        '{0, 0, scds_pkg::STATUS_OK}});
    vectors.push_back('{make_item(scds_pkg::ACT_WRITE_TARGET, 0, 0, 0, 0, 32'sh80000000), 1,
                        '{0, 0, scds_pkg::STATUS_SATURATED}});
    vectors.push_back('{make_item(scds_pkg::ACT_WRITE_TARGET, 0, 0, 4095, 0, 32'sh7fffffff),
                        1, '{0, 0, scds_pkg::STATUS_OK}});
    vectors.push_back('{make_item(scds_pkg::ACT_STEP, 0, 0, 0, 0, 0), 0, none});
    vectors.push_back('{make_item(scds_pkg::ACT_STEP, 0, 0, 0, 0, 0), 0, none});
    vectors.push_back('{make_item(scds_pkg::ACT_WRITE_ENTRY, 1, 0, 7, 1, 0), 0, none});
    vectors.push_back('{make_item(scds_pkg::ACT_WRITE_ENTRY, 1, 1, 7, 1, 0), 0, none});
    vectors.push_back('{make_item(scds_pkg::ACT_WRITE_TARGET, 1, 0, 7, 0, -2000000000), 0,
                        none});
    vectors.push_back('{make_item(scds_pkg::ACT_STEP, 1, 0, 0, 0, 0), 0, none});
    vectors.push_back('{make_item(scds_pkg::ACT_WRITE_ENTRY, 2, 2, 9, 16'sh8000, 0), 0, none});
    vectors.push_back('{make_item(scds_pkg::ACT_WRITE_ENTRY, 2, 1, 8, 16'sh7fff, 0), 0, none});
    vectors.push_back('{make_item(scds_pkg::ACT_WRITE_TARGET, 2, 0, 9, 0, 32'sh7fffffff), 0,
                        none});
    vectors.push_back('{make_item(scds_pkg::ACT_STEP, 2, 0, 0, 0, 0), 0, none});
    vectors.push_back('{make_item(scds_pkg::ACT_STEP, 1023, 0, 0, 0, 0), 1,
                        '{0, 0, scds_pkg::STATUS_ZERO_NORM}});
    vectors.push_back('{make_item(scds_pkg::ACT_READ_COORD, 1, 0, 0, 0, 0), 0, none});

    foreach (vectors[i]) issue(vectors[i].item, vectors[i].pinned, vectors[i].pinned_val);
    repeat (1130) issue(random_item(), 1'b0, none);

    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/scds_pkg.sv
rtl/scds_ram.sv
rtl/sparse_coordinate_descent_step_unit.sv
dv/tb.sv
